>>> sv/mm_pkg.sv
// Package for the matrix multiplier: constants, codes and shared types.
`timescale 1ns / 1ps
`default_nettype none
package mm_pkg;
  localparam int MAX_DIM_DEF   = 8;
  localparam int ELEM_BITS_DEF = 16;
  localparam int DIM_BITS      = 4;
  localparam int IDX_BITS      = 3;
  localparam int OP_BITS       = 2;
  localparam int VALUE_BITS    = 35;
  localparam int IN_BITS       = 16;

  typedef enum logic [OP_BITS-1:0] {
    OP_LOAD_A  = 2'd0,
    OP_LOAD_B  = 2'd1,
    OP_COMPUTE = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_t;

  localparam logic [1:0] REG_ROWS_A = 2'd0;
  localparam logic [1:0] REG_INNER  = 2'd1;
  localparam logic [1:0] REG_COLS_B = 2'd2;
endpackage
`default_nettype wire

>>> sv/mm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module mm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end
endmodule
`default_nettype wire

>>> sv/mm_cell.sv
// One cell of the accumulator chain: multiply-accumulate, then hand the sum on.
`timescale 1ns / 1ps
`default_nettype none
module mm_cell #(
  parameter int ELEM_BITS = 16
) (
  input  wire logic                             clk,
  input  wire logic                             en,
  input  wire logic                             clr,
  input  wire logic signed [ELEM_BITS-1:0]      a_in,
  input  wire logic signed [ELEM_BITS-1:0]      b_in,
  input  wire logic                             shift,
  input  wire logic [mm_pkg::VALUE_BITS-1:0]    sum_in,
  output logic      [mm_pkg::VALUE_BITS-1:0]    sum_out
);
  import mm_pkg::*;
  logic signed [2*ELEM_BITS-1:0] prod_r;
  logic                          pv_r;
  logic [VALUE_BITS-1:0]         acc_r;
  logic [VALUE_BITS-1:0]         prod_ext;

  // Sign-extend or truncate the product to the accumulator width.
  always_comb begin
    if (2*ELEM_BITS >= VALUE_BITS) begin
      prod_ext = VALUE_BITS'(prod_r);
    end else begin
      prod_ext = VALUE_BITS'(signed'(prod_r));
    end
  end

  // Registered product, then accumulation; shift hands sums down the chain.
  always_ff @(posedge clk) begin
    prod_r <= a_in * b_in;
    pv_r   <= en;
    if (shift) begin
      acc_r <= sum_in;
    end else if (clr) begin
      acc_r <= '0;
    end else if (pv_r) begin
      acc_r <= acc_r + prod_ext;
    end
  end

  assign sum_out = acc_r;
endmodule
`default_nettype wire

>>> sv/matrix_multiply_top.sv
// Top level of the matrix multiplier: registers, stores, sequencer and cell chain.
`timescale 1ns / 1ps
`default_nettype none
// A load word (operation 0 or 1) leaves busy low, so while no product runs loads
// stream one per cycle. A compute word runs one row of the product at a time: for
// each row, inner steps feed A[i][k] and row k of B (read element by element from the
// B store, one word a cycle) into a chain of MAX_DIM multiply-accumulate cells, one
// cell per product column. After the reads and the pipeline of each row, the row's
// sums shift out of the chain, one result word per cycle; the single read port of
// the B store sets the pace of a run. Results are shown for one cycle with out_valid
// and cannot be held off. Store contents read before they are written are undefined.
module matrix_multiply_top #(
  parameter int MAX_DIM   = mm_pkg::MAX_DIM_DEF,
  parameter int ELEM_BITS = mm_pkg::ELEM_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [mm_pkg::OP_BITS-1:0]        in_operation,
  input  wire logic [mm_pkg::IDX_BITS-1:0]       in_elem_row,
  input  wire logic [mm_pkg::IDX_BITS-1:0]       in_elem_col,
  input  wire logic signed [mm_pkg::IN_BITS-1:0] in_elem_value,
  output logic                                   out_valid,
  output logic [mm_pkg::IDX_BITS-1:0]            out_row,
  output logic [mm_pkg::IDX_BITS-1:0]            out_col,
  output logic signed [mm_pkg::VALUE_BITS-1:0]   out_value,
  output logic                                   out_last,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [3:0]                        paddr,
  input  wire logic [31:0]                       pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready
);
  import mm_pkg::*;
  localparam int IW    = $clog2(MAX_DIM);
  localparam int AW    = 2*IW;
  localparam int DEPTH = 2**AW;

  logic [DIM_BITS-1:0] rows_a_r, inner_r, cols_b_r;
  logic [DIM_BITS-1:0] nr, nk, nc;
  state_t state_r, state_nxt;

  // Configuration registers.
  logic [1:0] reg_idx;
  assign reg_idx = paddr[3:2];
  assign pready  = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r <= DIM_BITS'(8);
      inner_r  <= DIM_BITS'(8);
      cols_b_r <= DIM_BITS'(8);
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_ROWS_A: rows_a_r <= pwdata[DIM_BITS-1:0];
        REG_INNER:  inner_r  <= pwdata[DIM_BITS-1:0];
        REG_COLS_B: cols_b_r <= pwdata[DIM_BITS-1:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    unique case (reg_idx)
      REG_ROWS_A: prdata = 32'(rows_a_r);
      REG_INNER:  prdata = 32'(inner_r);
      REG_COLS_B: prdata = 32'(cols_b_r);
      default:    prdata = '0;
    endcase
  end

  // Dimensions saturated to MAX_DIM.
  assign nr = (rows_a_r > DIM_BITS'(MAX_DIM)) ? DIM_BITS'(MAX_DIM) : rows_a_r;
  assign nk = (inner_r  > DIM_BITS'(MAX_DIM)) ? DIM_BITS'(MAX_DIM) : inner_r;
  assign nc = (cols_b_r > DIM_BITS'(MAX_DIM)) ? DIM_BITS'(MAX_DIM) : cols_b_r;

  // Accept and load decode.
  logic accept, load_ok, we_a, we_b;
  logic [AW-1:0] waddr;
  logic [ELEM_BITS-1:0] wdata;
  assign accept  = start && !busy;
  assign load_ok = (32'(in_elem_row) < MAX_DIM) && (32'(in_elem_col) < MAX_DIM);
  assign we_a    = accept && load_ok && (op_t'(in_operation) == OP_LOAD_A);
  assign we_b    = accept && load_ok && (op_t'(in_operation) == OP_LOAD_B);
  assign waddr   = {in_elem_row[IW-1:0], in_elem_col[IW-1:0]};
  assign wdata   = ELEM_BITS'(in_elem_value);

  // Sequencer counters: row i, inner step k, column j.
  logic [DIM_BITS-1:0] i_r, i_nxt, k_r, k_nxt, j_r, j_nxt;
  logic                feed;
  logic [1:0]          tail_r, tail_nxt;
  logic [DIM_BITS-1:0] drain_r, drain_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept && op_t'(in_operation) == OP_COMPUTE && nr != 0 && nc != 0)
                 state_nxt = ST_RUN;
      ST_RUN:  if (tail_r == 2'd3) state_nxt = ST_DRAIN;
      ST_DRAIN: if (drain_r + 1'b1 == nc)
                  state_nxt = (i_r + 1'b1 == nr) ? ST_IDLE : ST_RUN;
      default: state_nxt = ST_IDLE;
    endcase
  end

  logic run_done, clr_row, shift_en;
  assign run_done = (k_r == nk) || (nk == 0);
  always_comb begin
    feed      = 1'b0;
    i_nxt     = i_r;
    k_nxt     = k_r;
    j_nxt     = j_r;
    tail_nxt  = tail_r;
    drain_nxt = drain_r;
    clr_row   = 1'b0;
    shift_en  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        i_nxt = '0; k_nxt = '0; j_nxt = '0; tail_nxt = '0; drain_nxt = '0;
        clr_row = 1'b1;
      end
      ST_RUN: begin
        if (!run_done) begin
          feed = 1'b1;
          if (j_r + 1'b1 == nc) begin
            j_nxt = '0;
            k_nxt = k_r + 1'b1;
          end else begin
            j_nxt = j_r + 1'b1;
          end
        end else begin
          tail_nxt = tail_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        shift_en  = 1'b1;
        drain_nxt = drain_r + 1'b1;
        if (drain_r + 1'b1 == nc) begin
          i_nxt = i_r + 1'b1; k_nxt = '0; j_nxt = '0; tail_nxt = '0; drain_nxt = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      i_r <= '0; k_r <= '0; j_r <= '0; tail_r <= '0; drain_r <= '0;
    end else begin
      state_r <= state_nxt;
      i_r <= i_nxt; k_r <= k_nxt; j_r <= j_nxt; tail_r <= tail_nxt; drain_r <= drain_nxt;
    end
  end
  assign busy = (state_r != ST_IDLE);

  // Stores: read A[i][k] and B[k][j] each feed cycle.
  logic [ELEM_BITS-1:0] a_rd, b_rd;
  logic [AW-1:0] a_raddr, b_raddr;
  assign a_raddr = {i_r[IW-1:0], k_r[IW-1:0]};
  assign b_raddr = {k_r[IW-1:0], j_r[IW-1:0]};
  mm_ram #(.WIDTH(ELEM_BITS), .DEPTH(DEPTH)) u_a_store (
    .clk(clk), .we(we_a), .waddr(waddr), .wdata(wdata), .raddr(a_raddr), .rdata(a_rd)
  );
  mm_ram #(.WIDTH(ELEM_BITS), .DEPTH(DEPTH)) u_b_store (
    .clk(clk), .we(we_b), .waddr(waddr), .wdata(wdata), .raddr(b_raddr), .rdata(b_rd)
  );

  // Registered column select after the read, aligned with the RAM data.
  logic           feed_q_r;
  logic [IW-1:0]  col_q_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      feed_q_r <= 1'b0;
    end else begin
      feed_q_r <= feed;
    end
    col_q_r <= j_r[IW-1:0];
  end

  // Chain of cells; cell c accumulates column c and shifts towards cell 0.
  logic [VALUE_BITS-1:0] sums [MAX_DIM+1];
  assign sums[MAX_DIM] = '0;
  for (genvar c = 0; c < MAX_DIM; c++) begin : g_cell
    mm_cell #(.ELEM_BITS(ELEM_BITS)) u_cell (
      .clk(clk),
      .en(feed_q_r && (col_q_r == IW'(c))),
      .clr(clr_row),
      .a_in(a_rd), .b_in(b_rd),
      .shift(shift_en),
      .sum_in(sums[c+1]),
      .sum_out(sums[c])
    );
  end

  // Result word, registered once.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= shift_en;
    end
    out_row   <= IDX_BITS'(i_r);
    out_col   <= IDX_BITS'(drain_r);
    out_value <= sums[0];
    out_last  <= (i_r + 1'b1 == nr) && (drain_r + 1'b1 == nc);
  end

  // Assertions.
  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (we_a || we_b) |-> !busy) else $error("store written while busy");
  a_out_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_DRAIN)) else $error("result outside drain");
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> state_r == ST_IDLE) else $error("last without idle");
endmodule
`default_nettype wire

>>> sim/matrix_multiply_top_tb.sv
// Testbench for the matrix multiplier: scoreboard, stimulus and result checking.
`timescale 1ns / 1ps
`default_nettype none

module matrix_multiply_top_tb;
  import mm_pkg::*;

  localparam int SETTLE_CYCLES = 700;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int ITEM_TARGET   = 210;
  localparam int CALM_FROM     = 180;

  // One product element as the block should present it.
  typedef struct {
    logic [IDX_BITS-1:0]          row;
    logic [IDX_BITS-1:0]          col;
    logic signed [VALUE_BITS-1:0] value;
    logic                         last;
  } product_t;

  // Scoreboard: keeps a copy of the stores and registers and the queue of
  // product elements still to come.
  class product_board;
    logic signed [IN_BITS-1:0] a_mem [MAX_DIM_DEF*MAX_DIM_DEF];
    logic signed [IN_BITS-1:0] b_mem [MAX_DIM_DEF*MAX_DIM_DEF];
    logic [DIM_BITS-1:0]       dim_rows, dim_inner, dim_cols;
    product_t                  due [$];
    int                        errors;

    function new();
      dim_rows  = 4'd8;
      dim_inner = 4'd8;
      dim_cols  = 4'd8;
      errors    = 0;
      foreach (a_mem[i]) begin
        a_mem[i] = '0;
        b_mem[i] = '0;
      end
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    function void set_reg(logic [1:0] idx, logic [3:0] val);
      case (idx)
        REG_ROWS_A: dim_rows  = val;
        REG_INNER:  dim_inner = val;
        REG_COLS_B: dim_cols  = val;
        default: ;
      endcase
    endfunction

    function int clamp(logic [DIM_BITS-1:0] d);
      return (d > MAX_DIM_DEF) ? MAX_DIM_DEF : int'(d);
    endfunction

    // Note an accepted input word and work out the products that it causes.
    function void note_word(op_t op, logic [2:0] r, logic [2:0] c,
                            logic signed [IN_BITS-1:0] v);
      int nr, nk, nc;
      longint acc;
      product_t p;
      if (op == OP_LOAD_A) begin
        a_mem[r*MAX_DIM_DEF + c] = v;
      end else if (op == OP_LOAD_B) begin
        b_mem[r*MAX_DIM_DEF + c] = v;
      end else if (op == OP_COMPUTE) begin
        nr = clamp(dim_rows);
        nk = clamp(dim_inner);
        nc = clamp(dim_cols);
        for (int i = 0; i < nr; i++) begin
          for (int j = 0; j < nc; j++) begin
            acc = 0;
            for (int k = 0; k < nk; k++)
              acc += longint'(a_mem[i*MAX_DIM_DEF + k]) * longint'(b_mem[k*MAX_DIM_DEF + j]);
            p.row   = i[2:0];
            p.col   = j[2:0];
            p.value = acc[VALUE_BITS-1:0];
            p.last  = (i == nr - 1) && (j == nc - 1);
            due.insert(due.size(), p);
          end
        end
      end
    endfunction

    // Compare a product element from the block with the oldest expectation.
    task check_product(product_t got);
      product_t want;
      if (due.size() == 0) begin
        report($sformatf("unexpected product row %0d col %0d", got.row, got.col));
        return;
      end
      want = due.pop_front();
      if (got.row !== want.row)
        report($sformatf("row got %0d want %0d", got.row, want.row));
      if (got.col !== want.col)
        report($sformatf("col got %0d want %0d", got.col, want.col));
      if (got.value !== want.value)
        report($sformatf("value at (%0d,%0d) got %0d want %0d",
                         want.row, want.col, got.value, want.value));
      if (got.last !== want.last)
        report($sformatf("last at (%0d,%0d) got %0b want %0b",
                         want.row, want.col, got.last, want.last));
    endtask
  endclass

  logic                         clk;
  logic                         rst_n;
  logic                         start;
  logic                         busy;
  logic [OP_BITS-1:0]           in_operation;
  logic [IDX_BITS-1:0]          in_elem_row;
  logic [IDX_BITS-1:0]          in_elem_col;
  logic signed [IN_BITS-1:0]    in_elem_value;
  logic                         out_valid;
  logic [IDX_BITS-1:0]          out_row;
  logic [IDX_BITS-1:0]          out_col;
  logic signed [VALUE_BITS-1:0] out_value;
  logic                         out_last;
  logic                         psel, penable, pwrite;
  logic [3:0]                   paddr;
  logic [31:0]                  pwdata;
  logic [31:0]                  prdata;
  logic                         pready;

  product_board board;
  bit   a_written [MAX_DIM_DEF*MAX_DIM_DEF];
  bit   b_written [MAX_DIM_DEF*MAX_DIM_DEF];
  int   words_sent;
  int   cycles;
  bit   calm;

  matrix_multiply_top u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_operation(in_operation), .in_elem_row(in_elem_row),
    .in_elem_col(in_elem_col), .in_elem_value(in_elem_value),
    .out_valid(out_valid), .out_row(out_row), .out_col(out_col),
    .out_value(out_value), .out_last(out_last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Clock.
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Cycle counter and run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    product_t got;
    if (rst_n && out_valid) begin
      got.row   = out_row;
      got.col   = out_col;
      got.value = out_value;
      got.last  = out_last;
      board.check_product(got);
    end
  end

  // Send one input word and wait until the block takes it.
  task automatic send_word(op_t op, logic [2:0] r, logic [2:0] c,
                           logic signed [IN_BITS-1:0] v);
    @(negedge clk);
    start         <= 1'b1;
    in_operation  <= op;
    in_elem_row   <= r;
    in_elem_col   <= c;
    in_elem_value <= v;
    do @(posedge clk); while (busy);
    board.note_word(op, r, c, v);
    if (op == OP_LOAD_A) a_written[r*MAX_DIM_DEF + c] = 1'b1;
    if (op == OP_LOAD_B) b_written[r*MAX_DIM_DEF + c] = 1'b1;
    words_sent++;
  endtask

  // Occasional burst of idle cycles on the input side.
  task automatic maybe_idle();
    int n;
    if (!calm && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 18);
      @(negedge clk);
      start <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Write one register through the APB port.
  task automatic write_reg(logic [1:0] idx, logic [3:0] val);
    @(negedge clk);
    start   <= 1'b0;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {28'd0, val};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    board.set_reg(idx, val);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Wait until every expected product has come and the block is quiet.
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (board.due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_shape(logic [3:0] r, logic [3:0] k, logic [3:0] c);
    settle();
    write_reg(REG_ROWS_A, r);
    write_reg(REG_INNER, k);
    write_reg(REG_COLS_B, c);
  endtask

  // Load every element that the coming product reads but that was never written.
  task automatic fill_missing();
    int nr, nk, nc;
    nr = board.clamp(board.dim_rows);
    nk = board.clamp(board.dim_inner);
    nc = board.clamp(board.dim_cols);
    for (int i = 0; i < nr; i++)
      for (int k = 0; k < nk; k++)
        if (!a_written[i*MAX_DIM_DEF + k]) begin
          send_word(OP_LOAD_A, i[2:0], k[2:0], 16'($urandom));
          maybe_idle();
        end
    for (int k = 0; k < nk; k++)
      for (int j = 0; j < nc; j++)
        if (!b_written[k*MAX_DIM_DEF + j]) begin
          send_word(OP_LOAD_B, k[2:0], j[2:0], 16'($urandom));
          maybe_idle();
        end
  endtask

  task automatic random_shape();
    logic [3:0] d [3];
    foreach (d[i]) begin
      case ($urandom_range(0, 9))
        0:       d[i] = 4'd0;
        1:       d[i] = 4'($urandom_range(9, 15));
        2:       d[i] = 4'd8;
        default: d[i] = 4'($urandom_range(1, 4));
      endcase
    end
    set_shape(d[0], d[1], d[2]);
  endtask

  initial begin
    logic signed [IN_BITS-1:0] v;
    board         = new();
    cycles        = 0;
    words_sent    = 0;
    calm          = 1'b0;
    rst_n         = 1'b0;
    start         = 1'b0;
    in_operation  = '0;
    in_elem_row   = '0;
    in_elem_col   = '0;
    in_elem_value = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    foreach (a_written[i]) begin
      a_written[i] = 1'b0;
      b_written[i] = 1'b0;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: extreme values on a 2 by 2 by 2 product.
    set_shape(4'd2, 4'd2, 4'd2);
    send_word(OP_LOAD_A, 3'd0, 3'd0, 16'sh7fff);
    send_word(OP_LOAD_A, 3'd0, 3'd1, 16'sh7fff);
    send_word(OP_LOAD_A, 3'd1, 3'd0, -16'sd32768);
    send_word(OP_LOAD_A, 3'd1, 3'd1, 16'sd0);
    send_word(OP_LOAD_B, 3'd0, 3'd0, 16'sh7fff);
    send_word(OP_LOAD_B, 3'd1, 3'd0, 16'sh7fff);
    send_word(OP_LOAD_B, 3'd0, 3'd1, -16'sd32768);
    send_word(OP_LOAD_B, 3'd1, 3'd1, -16'sd1);
    send_word(OP_COMPUTE, 3'd0, 3'd0, 16'sd0);
    send_word(OP_NONE, 3'd7, 3'd7, -16'sd1);
    send_word(OP_LOAD_A, 3'd7, 3'd7, -16'sd32768);
    send_word(OP_LOAD_B, 3'd7, 3'd7, 16'sh7fff);
    send_word(OP_COMPUTE, 3'd7, 3'd7, -16'sd1);
    // Empty products, a zero inner dimension and saturated registers.
    set_shape(4'd0, 4'd2, 4'd2);
    send_word(OP_COMPUTE, 3'd0, 3'd0, 16'sd0);
    set_shape(4'd2, 4'd2, 4'd0);
    send_word(OP_COMPUTE, 3'd0, 3'd0, 16'sd0);
    set_shape(4'd2, 4'd0, 4'd2);
    send_word(OP_COMPUTE, 3'd0, 3'd0, 16'sd0);
    set_shape(4'd1, 4'd1, 4'd1);
    send_word(OP_COMPUTE, 3'd0, 3'd0, 16'sd0);
    set_shape(4'd15, 4'd15, 4'd15);
    fill_missing();
    send_word(OP_COMPUTE, 3'd0, 3'd0, 16'sd0);

    // Random part: mostly loads followed by a product, some noise words.
    while (words_sent < ITEM_TARGET) begin
      if (words_sent >= CALM_FROM) calm = 1'b1;
      if ($urandom_range(0, 2) == 0) random_shape();
      fill_missing();
      repeat ($urandom_range(0, 8)) begin
        v = 16'($urandom);
        case ($urandom_range(0, 9))
          0:       send_word(OP_NONE, 3'($urandom), 3'($urandom), v);
          1, 2, 3,
          4:       send_word(OP_LOAD_A, 3'($urandom), 3'($urandom), v);
          default: send_word(OP_LOAD_B, 3'($urandom), 3'($urandom), v);
        endcase
        maybe_idle();
      end
      send_word(OP_COMPUTE, 3'($urandom), 3'($urandom), 16'($urandom));
      maybe_idle();
    end

    settle();
    if (board.due.size() != 0)
      board.report($sformatf("%0d products never arrived", board.due.size()));
    if (board.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
`default_nettype wire
